// ===== hw/rtl/ntaf_pkg.sv =====
// ---------------------------------------------------------------------------
// ntaf_pkg: shared types and constants for the number-to-ASCII formatter.
// Holds the command codes, the request descriptor that travels from the
// front end to the back end, and the power-of-ten tables.
// ---------------------------------------------------------------------------
package ntaf_pkg;

    // Command codes as they arrive on the command port.
    localparam logic [1:0] CMD_LIT = 2'd0;
    localparam logic [1:0] CMD_DEC = 2'd1;
    localparam logic [1:0] CMD_HEX = 2'd2;

    // Default depth of the request queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Largest digit position: five decimal digits, positions 4 down to 0.
    localparam logic [2:0] POS_MAX_DEC = 3'd4;
    localparam logic [2:0] POS_MAX_HEX = 3'd3;

    // ASCII bases.
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A    = 8'h61;

    // Classified kind of a request.
    typedef enum logic [1:0] {
        MODE_LIT,
        MODE_DEC,
        MODE_HEX
    } mode_t;

    // Request descriptor: kind, the value, and the position of the first
    // character to emit. Characters are emitted from pos down to zero.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] value;
        logic [2:0]  pos;
    } desc_t;

    // Write side of the request queue.
    typedef struct packed {
        logic  push;
        desc_t data;
    } q_wr_t;

    // Read side of the request queue.
    typedef struct packed {
        logic  valid;
        desc_t data;
    } q_rd_t;

    // Power of ten for a decimal position, 17 bits wide to match the
    // digit multiples below.
    function automatic logic [16:0] pow10(input logic [2:0] pos);
        logic [16:0] p;
        begin
            case (pos)
                3'd0:    p = 17'd1;
                3'd1:    p = 17'd10;
                3'd2:    p = 17'd100;
                3'd3:    p = 17'd1000;
                3'd4:    p = 17'd10000;
                default: p = 17'd0;
            endcase
            return p;
        end
    endfunction

    // Digit times the power of ten for a position (a 10 by 5 constant table).
    function automatic logic [16:0] digit_weight(input logic [3:0] d,
                                                 input logic [2:0] pos);
        logic [16:0] w;
        begin
            case (pos)
                3'd0:    w = 17'(d);
                3'd1:    w = 17'(d) * 17'd10;
                3'd2:    w = 17'(d) * 17'd100;
                3'd3:    w = 17'(d) * 17'd1000;
                3'd4:    w = 17'(d) * 17'd10000;
                default: w = 17'd0;
            endcase
            return w;
        end
    endfunction

endpackage

// ===== hw/rtl/ntaf_front.sv =====
// ---------------------------------------------------------------------------
// ntaf_front: request intake and classification.
// Takes a request when start is high and the queue has room, works out the
// kind of request and how many characters it produces, and pushes a
// descriptor into the request queue.
// ---------------------------------------------------------------------------
module ntaf_front (
    input  logic                 start,
    input  logic [1:0]           command,
    input  logic [15:0]          value,
    input  logic [2:0]           hex_digits,
    input  logic                 q_full,
    output logic                 busy,
    output ntaf_pkg::q_wr_t      q_wr
);

    ntaf_pkg::desc_t desc;
    logic [2:0]      dec_pos;
    logic [2:0]      hex_pos;

    // The front end is busy exactly when the queue cannot take a request.
    assign busy = q_full;

    // Highest nonzero decimal position; zero keeps a single '0'.
    always_comb
    begin
        if (value >= 16'd10000)
            dec_pos = 3'd4;
        else if (value >= 16'd1000)
            dec_pos = 3'd3;
        else if (value >= 16'd100)
            dec_pos = 3'd2;
        else if (value >= 16'd10)
            dec_pos = 3'd1;
        else
            dec_pos = 3'd0;
    end

    // Hex digit count limited to one through four.
    always_comb
    begin
        if (hex_digits == 3'd0)
            hex_pos = 3'd0;
        else if (hex_digits > 3'd4)
            hex_pos = ntaf_pkg::POS_MAX_HEX;
        else
            hex_pos = hex_digits - 3'd1;
    end

    // Classify the command; the unused code behaves as a literal.
    always_comb
    begin
        desc.value = value;
        unique case (command)
            ntaf_pkg::CMD_DEC:
            begin
                desc.mode = ntaf_pkg::MODE_DEC;
                desc.pos  = dec_pos;
            end
            ntaf_pkg::CMD_HEX:
            begin
                desc.mode = ntaf_pkg::MODE_HEX;
                desc.pos  = hex_pos;
            end
            default:
            begin
                desc.mode = ntaf_pkg::MODE_LIT;
                desc.pos  = 3'd0;
            end
        endcase
    end

    assign q_wr.push = start && !q_full;
    assign q_wr.data = desc;

endmodule

// ===== hw/rtl/ntaf_queue.sv =====
// ---------------------------------------------------------------------------
// ntaf_queue: short first-in first-out queue of request descriptors.
// Decouples the front end from the back end so that a new request can be
// taken while the previous one is still being emitted.
// ---------------------------------------------------------------------------
module ntaf_queue #(
    parameter int DEPTH = ntaf_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ntaf_pkg::q_wr_t  q_wr,
    input  logic             pop,
    output ntaf_pkg::q_rd_t  q_rd,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ntaf_pkg::desc_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = q_wr.push && !full;
    assign do_pop  = pop && (count_reg != '0);

    // Pointer and fill count updates with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == PTR_W'(DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == PTR_W'(DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Descriptor storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_wr.data;
    end

    assign q_rd.valid = (count_reg != '0);
    assign q_rd.data  = mem[rd_ptr_reg];

endmodule

// ===== hw/rtl/ntaf_back.sv =====
// ---------------------------------------------------------------------------
// ntaf_back: character emitter.
// Pulls descriptors from the request queue and emits one ASCII character
// per cycle, from the highest position down to position zero, flagging the
// last one. Decimal digits are found by comparing the remainder against the
// nine multiples of the position's power of ten.
// ---------------------------------------------------------------------------
module ntaf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ntaf_pkg::q_rd_t  q_rd,
    output logic             pop,
    output logic             strobe,
    output logic [7:0]       ascii_char,
    output logic             last
);

    logic               active_reg, active_next;
    ntaf_pkg::mode_t    mode_reg,   mode_next;
    logic [15:0]        rem_reg,    rem_next;
    logic [2:0]         pos_reg,    pos_next;
    logic               strobe_reg, strobe_next;
    logic [7:0]         char_reg,   char_next;
    logic               last_reg,   last_next;

    logic [3:0]         dec_digit;
    logic [16:0]        dec_weight;
    logic [3:0]         nibble;
    logic [15:0]        hex_shifted;
    logic [7:0]         emit_char;
    logic               load;

    // Decimal digit at the current position: largest k with k*10^pos <= rem.
    always_comb
    begin
        dec_digit = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({1'b0, rem_reg} >= ntaf_pkg::digit_weight(4'(k), pos_reg))
                dec_digit = 4'(k);
        end
        dec_weight = ntaf_pkg::digit_weight(dec_digit, pos_reg);
    end

    // Hex nibble at the current position.
    assign hex_shifted = rem_reg >> {pos_reg[1:0], 2'b00};
    assign nibble      = hex_shifted[3:0];

    // Character for the current position.
    always_comb
    begin
        unique case (mode_reg)
            ntaf_pkg::MODE_DEC:
                emit_char = ntaf_pkg::ASCII_ZERO + {4'd0, dec_digit};
            ntaf_pkg::MODE_HEX:
            begin
                if (nibble < 4'd10)
                    emit_char = ntaf_pkg::ASCII_ZERO + {4'd0, nibble};
                else
                    emit_char = ntaf_pkg::ASCII_A + {4'd0, nibble - 4'd10};
            end
            default:
                emit_char = rem_reg[7:0];
        endcase
    end

    // Take the next request when idle or on the last character of this one.
    assign load = q_rd.valid && (!active_reg || (pos_reg == 3'd0));
    assign pop  = load;

    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;

        if (active_reg)
        begin
            strobe_next = 1'b1;
            char_next   = emit_char;
            last_next   = (pos_reg == 3'd0);
            if (pos_reg != 3'd0)
            begin
                pos_next = pos_reg - 3'd1;
                if (mode_reg == ntaf_pkg::MODE_DEC)
                    rem_next = rem_reg - dec_weight[15:0];
            end
        end

        if (load)
        begin
            active_next = 1'b1;
            mode_next   = q_rd.data.mode;
            rem_next    = q_rd.data.value;
            pos_next    = q_rd.data.pos;
        end
        else if (active_reg && (pos_reg == 3'd0))
        begin
            active_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        rem_reg  <= rem_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

endmodule

// ===== hw/rtl/number_to_ascii_formatter.sv =====
// ---------------------------------------------------------------------------
// number_to_ascii_formatter: formats a 16-bit value as ASCII characters.
// A request is a literal byte, an unsigned decimal number or a lower-case
// hex number; the characters leave one per cycle with the last one flagged.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------------------
//   request   start / busy         command, value, hex_digits
//   result    strobe (one cycle)   ascii_char, last
//
// A request producing one to five characters holds the character emitter
// while they leave; requests follow each other with no gap, so the
// sustained rate is one character per cycle while requests are queued.
// The first character follows the request queue and the emitter's registers.
// busy rises only when the request queue is full; the result side cannot
// stall. Reset empties the queue and idles the emitter.
// ---------------------------------------------------------------------------
module number_to_ascii_formatter #(
    parameter int QUEUE_DEPTH = ntaf_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [15:0] value,
    input  logic [2:0]  hex_digits,
    output logic        strobe,
    output logic [7:0]  ascii_char,
    output logic        last
);

    ntaf_pkg::q_wr_t q_wr;
    ntaf_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            q_pop;

    // Request intake and classification.
    ntaf_front u_front (
        .start      (start),
        .command    (command),
        .value      (value),
        .hex_digits (hex_digits),
        .q_full     (q_full),
        .busy       (busy),
        .q_wr       (q_wr)
    );

    // Request queue.
    ntaf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .q_rd  (q_rd),
        .full  (q_full)
    );

    // Character emitter.
    ntaf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rd       (q_rd),
        .pop        (q_pop),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule

// ===== tb/sv/number_to_ascii_formatter_test.sv =====
// ---------------------------------------------------------------------------
// number_to_ascii_formatter_test: self-checking bench for the formatter.
// Requests go in through start/busy and the characters are checked one by one
// against a predictor that formats each request in the bench itself. It covers
// literal, decimal and hex requests, every hex digit count the port allows,
// random idle gaps on the request side, and a pause until the output drains.
// ---------------------------------------------------------------------------
module number_to_ascii_formatter_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The command port is two bits wide; the top code has no name in the package.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int unsigned TOP_DECADE     = 10000;
    localparam int unsigned RANDOM_ITEMS   = 345;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;

    // One character as it should leave the block.
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  command = ntaf_pkg::CMD_LIT;
    logic [15:0] value = 16'h0000;
    logic [2:0]  hex_digits = 3'd1;
    logic        strobe;
    logic [7:0]  ascii_char;
    logic        last;

    char_t       expected_chars[$];
    bit          steady = 1'b0;
    int unsigned error_count = 0;
    int unsigned chars_checked = 0;
    int unsigned idle_cycles = 0;
    int unsigned requests_by_cmd[4] = '{0, 0, 0, 0};

    number_to_ascii_formatter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .value      (value),
        .hex_digits (hex_digits),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last       (last)
    );

    // Free-running clock, 12 ns period.
    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Append one character to the expected stream, not yet flagged as last.
    function automatic void push_char(input logic [7:0] ch);
        char_t c;
        c.ch   = ch;
        c.last = 1'b0;
        expected_chars.push_back(c);
    endfunction

    // Work out the characters of one request and flag the final one.
    function automatic void predict_chars(input logic [1:0] cmd, input logic [15:0] val,
                                          input logic [2:0] dig);
        int unsigned rest;
        int unsigned weight;
        int unsigned d;
        int unsigned count;
        logic [3:0]  nib;
        bit          leading;
        begin
            case (cmd)
                ntaf_pkg::CMD_DEC:
                begin
                    if (val == 16'd0)
                    begin
                        push_char(ntaf_pkg::ASCII_ZERO);
                    end
                    else
                    begin
                        rest    = 32'(val);
                        weight  = TOP_DECADE;
                        leading = 1'b1;
                        while (weight > 0)
                        begin
                            d    = rest / weight;
                            rest = rest % weight;
                            if (d != 0 || !leading)
                            begin
                                push_char(ntaf_pkg::ASCII_ZERO + 8'(d));
                                leading = 1'b0;
                            end
                            weight = weight / 10;
                        end
                    end
                end
                ntaf_pkg::CMD_HEX:
                begin
                    // A count of zero gives one digit, anything above four gives four.
                    count = (dig == 3'd0) ? 1 : (dig > 3'd4) ? 4 : 32'(dig);
                    for (int i = int'(count) - 1; i >= 0; i--)
                    begin
                        nib = 4'(val >> (4 * i));
                        if (nib < 4'd10)
                            push_char(ntaf_pkg::ASCII_ZERO + 8'(nib));
                        else
                            push_char(ntaf_pkg::ASCII_A + 8'(nib - 4'd10));
                    end
                end
                default:
                begin
                    // Literal and the spare code both pass the low byte through.
                    push_char(val[7:0]);
                end
            endcase
            expected_chars[expected_chars.size() - 1].last = 1'b1;
        end
    endfunction

    // Random value spread over all decimal lengths, with the top value now and then.
    function automatic logic [15:0] random_value();
        logic [15:0] v;
        begin
            case ($urandom_range(6))
                0:       v = 16'($urandom_range(9));
                1:       v = 16'($urandom_range(99));
                2:       v = 16'($urandom_range(999));
                3:       v = 16'($urandom_range(9999));
                4:       v = 16'hFFFF;
                default: v = 16'($urandom_range(65535));
            endcase
            return v;
        end
    endfunction

    // Request monitor and character checker, both sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_chars.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected character %h last %b at %0t",
                                 ascii_char, last, $realtime);
                end
                else
                begin
                    char_t exp_c;
                    exp_c = expected_chars.pop_front();
                    chars_checked++;
                    if (ascii_char !== exp_c.ch || last !== exp_c.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("ERROR: char %h last %b, expected char %h last %b at %0t",
                                     ascii_char, last, exp_c.ch, exp_c.last, $realtime);
                    end
                end
            end
            if (start && !busy)
            begin
                requests_by_cmd[command]++;
                predict_chars(command, value, hex_digits);
            end
        end
    end

    // Watchdog: too many cycles with neither a request taken nor a character out.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("number_to_ascii_formatter test failed");
            $finish;
        end
    end

    // Send one request, with random idle cycles ahead of it unless running steady.
    task automatic send_request(input logic [1:0] cmd, input logic [15:0] val,
                                input logic [2:0] dig);
        if (!steady)
        begin
            while ($urandom_range(99) < 22)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start      <= 1'b1;
        command    <= cmd;
        value      <= val;
        hex_digits <= dig;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending and wait until every predicted character has come out.
    task automatic wait_all_chars();
        start <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // Literal bytes at the extremes, plus the spare command code.
    task automatic test_literal();
        send_request(ntaf_pkg::CMD_LIT, 16'h0000, 3'd0);
        send_request(ntaf_pkg::CMD_LIT, 16'hFFFF, 3'd7);
        send_request(ntaf_pkg::CMD_LIT, 16'h3441, 3'd2);
        send_request(CMD_SPARE, 16'hA5C3, 3'd4);
    endtask

    // Decimal values at every length boundary and the largest value.
    task automatic test_decimal();
        send_request(ntaf_pkg::CMD_DEC, 16'd0, 3'd1);
        send_request(ntaf_pkg::CMD_DEC, 16'd9, 3'd1);
        send_request(ntaf_pkg::CMD_DEC, 16'd10, 3'd1);
        send_request(ntaf_pkg::CMD_DEC, 16'd100, 3'd1);
        send_request(ntaf_pkg::CMD_DEC, 16'd999, 3'd1);
        send_request(ntaf_pkg::CMD_DEC, 16'd9999, 3'd1);
        send_request(ntaf_pkg::CMD_DEC, 16'd10000, 3'd1);
        send_request(ntaf_pkg::CMD_DEC, 16'd10001, 3'd1);
        send_request(ntaf_pkg::CMD_DEC, 16'd65535, 3'd1);
    endtask

    // Hex with every digit count the port can carry, including zero and above four.
    task automatic test_hex();
        for (int d = 0; d < 8; d++)
            send_request(ntaf_pkg::CMD_HEX, 16'hFEDC, 3'(d));
        send_request(ntaf_pkg::CMD_HEX, 16'h0000, 3'd4);
        send_request(ntaf_pkg::CMD_HEX, 16'h1B9A, 3'd4);
    endtask

    // Let the output drain fully in the middle of a burst of requests.
    task automatic test_drain_pause();
        for (int i = 0; i < 6; i++)
            send_request(ntaf_pkg::CMD_DEC, random_value(), 3'd1);
        wait_all_chars();
        for (int i = 0; i < 6; i++)
            send_request(ntaf_pkg::CMD_HEX, random_value(), 3'($urandom_range(1, 4)));
        wait_all_chars();
    endtask

    // Random mix of commands; a stretch in the middle runs with no idle cycles.
    task automatic test_random(input int unsigned n_items);
        int unsigned pick;
        logic [1:0]  cmd;
        logic [2:0]  dig;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            steady = (i >= n_items / 3) && (i < n_items / 3 + n_items / 4);
            pick   = $urandom_range(99);
            if (pick < 15)
                cmd = ntaf_pkg::CMD_LIT;
            else if (pick < 20)
                cmd = CMD_SPARE;
            else if (pick < 60)
                cmd = ntaf_pkg::CMD_DEC;
            else
                cmd = ntaf_pkg::CMD_HEX;
            // Mostly legal digit counts, sometimes any code the port allows.
            if ($urandom_range(9) < 8)
                dig = 3'($urandom_range(1, 4));
            else
                dig = 3'($urandom_range(7));
            send_request(cmd, ($urandom_range(3) == 0) ? 16'($urandom()) : random_value(),
                         dig);
        end
        steady = 1'b0;
    endtask

    // Test sequence.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literal();
        test_decimal();
        test_hex();
        test_drain_pause();
        test_random(RANDOM_ITEMS);

        wait_all_chars();
        repeat (12) @(posedge clk);

        $display("Covered %0d literal, %0d spare-code, %0d decimal and %0d hex requests;",
                 requests_by_cmd[ntaf_pkg::CMD_LIT], requests_by_cmd[CMD_SPARE],
                 requests_by_cmd[ntaf_pkg::CMD_DEC], requests_by_cmd[ntaf_pkg::CMD_HEX]);
        $display("%0d characters checked, %0d mismatches, %0d still pending.",
                 chars_checked, error_count, expected_chars.size());
        if (error_count == 0 && expected_chars.size() == 0)
            $display("number_to_ascii_formatter test passed");
        else
            $display("number_to_ascii_formatter test failed");
        $finish;
    end

endmodule
